// ===== rtl/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache model.
`timescale 1ns / 1ps

package salc_pkg;

  // Field widths of the stream words.
  localparam int OP_W      = 2;
  localparam int ADDR_W    = 64;
  localparam int TOTAL_W   = 32;
  localparam int HITCNT_W  = 2;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 104;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SET_BITS_W = 3;
  localparam int WAYS_W     = 4;
  localparam int OFFSET_W   = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd2;

  // Only bit 1 of the op code is decoded: set means modify.
  localparam int OP_MODIFY_BIT = 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

// ===== rtl/set_assoc_lru_cache_model_core.sv =====
// Top level of the set-associative LRU cache model.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tuser = op, s_tdata = address
//   m_*       out  m_tvalid/m_tready  m_tdata = outcome flags and totals
//   cfg_*     in   cfg_wr_en          cfg_index, cfg_data
//
// Each access is accepted in the idle state, where the set's row is read
// from the tag RAM; in the lookup state that follows, all ways are compared,
// the ranks are updated and the row is written back.
// After reset a clearing pass writes zero to each of the 2^MAX_SET_BITS rows;
// no access is taken until it ends. A result waiting in the output register
// stalls the lookup cycle of the next access only.
`timescale 1ns / 1ps

module set_assoc_lru_cache_model_core #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // fields: op[1:0]
  input  logic [salc_pkg::OP_W-1:0]            s_tuser,
  // fields: address[63:0]
  input  logic [salc_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // fields: hit_count[1:0], missed[2], evicted[3], total_hits[35:4],
  // total_misses[67:36], total_evictions[99:68], zero pad[103:100]
  output logic [salc_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_wr_en,
  input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SETS    = 1 << MAX_SET_BITS;
  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TAG_W   = salc_pkg::ADDR_W;
  localparam int WAY_W   = 1 + TAG_W + RANK_W;
  localparam int ROW_W   = MAX_WAYS * WAY_W;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1) + 1;
  localparam int TOTAL_W = salc_pkg::TOTAL_W;
  // Way layout inside a row: rank in the low bits, then tag, then valid.
  localparam int TAG_LSB = RANK_W;
  localparam int VLD_BIT = RANK_W + TAG_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
  localparam logic [SET_W-1:0]  LAST_SET = SET_W'(SETS - 1);

  salc_pkg::state_t state, state_next;

  logic [salc_pkg::SET_BITS_W-1:0] set_index_bits;
  logic [salc_pkg::WAYS_W-1:0]     ways_in_use;
  logic [salc_pkg::OFFSET_W-1:0]   offset_bits;

  logic [SET_W-1:0] clr_idx;
  logic             cur_modify;
  logic [TAG_W-1:0] cur_block;
  logic [SET_W-1:0] cur_set;

  logic [TOTAL_W-1:0] hit_total, miss_total, eviction_total;
  logic               out_valid;
  logic [1:0]         out_hit_count;
  logic               out_missed, out_evicted;

  logic             accept, load;
  logic [TAG_W-1:0] in_block;
  logic [SET_W-1:0] in_set;
  logic [3:0]       index_bits_eff;
  logic [WCNT_W-1:0] ways_eff;

  logic             ram_wr_en;
  logic [SET_W-1:0] ram_wr_addr;
  logic [ROW_W-1:0] ram_wr_data;
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_new;

  logic found, has_free, res_evicted;
  logic [1:0] res_hit_count;
  logic [1:0] hit_inc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= '0;
      ways_in_use    <= salc_pkg::WAYS_W'(1);
      offset_bits    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        salc_pkg::CFG_SET_INDEX_BITS: set_index_bits <= cfg_data[salc_pkg::SET_BITS_W-1:0];
        salc_pkg::CFG_WAYS_IN_USE:    ways_in_use    <= cfg_data[salc_pkg::WAYS_W-1:0];
        salc_pkg::CFG_OFFSET_BITS:    offset_bits    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry.
  always_comb begin
    if (int'(set_index_bits) > MAX_SET_BITS) begin
      index_bits_eff = 4'(MAX_SET_BITS);
    end else begin
      index_bits_eff = 4'(set_index_bits);
    end
    if (ways_in_use == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_in_use);
    end
  end

  // Block address and set of the incoming word.
  always_comb begin
    in_block = s_tdata[salc_pkg::ADDR_W-1:0] >> offset_bits;
    for (int i = 0; i < SET_W; i++) begin
      in_set[i] = in_block[i] & (i < int'(index_bits_eff));
    end
  end

  assign s_tready = (state == salc_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load     = (state == salc_pkg::ST_LOOKUP) && (!out_valid || m_tready);

  // State machine.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= salc_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == salc_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + SET_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      salc_pkg::ST_CLEAR: begin
        if (clr_idx == LAST_SET) begin
          state_next = salc_pkg::ST_IDLE;
        end
      end
      salc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = salc_pkg::ST_LOOKUP;
        end
      end
      salc_pkg::ST_LOOKUP: begin
        if (load) begin
          state_next = salc_pkg::ST_IDLE;
        end
      end
      default: state_next = salc_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_modify <= s_tuser[salc_pkg::OP_MODIFY_BIT];
      cur_block  <= in_block;
      cur_set    <= in_set;
    end
  end

  // Tag, valid and rank of every way of a set share one row.
  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (in_set),
    .rd_data (row_rd)
  );

  // Lookup, victim choice and rank update on the row that was read.
  always_comb begin
    logic [MAX_WAYS-1:0] way_used;
    logic [MAX_WAYS-1:0] way_valid;
    logic [RANK_W-1:0]   rank [MAX_WAYS];
    logic [RANK_W-1:0]   hit_rank;
    logic [RANK_W-1:0]   best;
    int                  hit_way, free_way, lru_way, chosen;
    logic                age_ok;

    found    = 1'b0;
    has_free = 1'b0;
    hit_way  = 0;
    free_way = 0;
    lru_way  = 0;
    best     = '0;
    hit_rank = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_used[w]  = (w < int'(ways_eff));
      way_valid[w] = row_rd[w*WAY_W + VLD_BIT];
      rank[w]      = row_rd[w*WAY_W +: RANK_W];
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (way_used[w] && way_valid[w] &&
          row_rd[w*WAY_W + TAG_LSB +: TAG_W] == cur_block) begin
        found   = 1'b1;
        hit_way = w;
      end
      if (way_used[w] && !way_valid[w]) begin
        has_free = 1'b1;
        free_way = w;
      end
    end
    // Oldest way; a tie goes to the lowest index.
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (way_used[w] && (w == 0 || rank[w] > best)) begin
        best    = rank[w];
        lru_way = w;
      end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w == hit_way) begin
        hit_rank = rank[w];
      end
    end
    if (found) begin
      chosen = hit_way;
    end else if (has_free) begin
      chosen = free_way;
    end else begin
      chosen = lru_way;
    end

    row_new = row_rd;
    for (int w = 0; w < MAX_WAYS; w++) begin
      age_ok = !found || (rank[w] < hit_rank);
      if (w == chosen) begin
        row_new[w*WAY_W +: RANK_W] = '0;
        if (!found) begin
          row_new[w*WAY_W + VLD_BIT]            = 1'b1;
          row_new[w*WAY_W + TAG_LSB +: TAG_W]   = cur_block;
        end
      end else if (way_used[w] && way_valid[w] && age_ok && rank[w] != RANK_MAX) begin
        row_new[w*WAY_W +: RANK_W] = rank[w] + RANK_W'(1);
      end
    end

    res_evicted   = !found && !has_free;
    hit_inc       = {1'b0, found} + {1'b0, cur_modify};
    res_hit_count = hit_inc;
  end

  always_comb begin
    if (state == salc_pkg::ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_idx;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = load;
      ram_wr_addr = cur_set;
      ram_wr_data = row_new;
    end
  end

  // Totals and the output register.
  always_ff @(posedge clk) begin
    logic [TOTAL_W:0] hit_sum;
    hit_sum = {1'b0, hit_total} + (TOTAL_W + 1)'(hit_inc);
    if (rst) begin
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        hit_total <= hit_sum[TOTAL_W] ? '1 : hit_sum[TOTAL_W-1:0];
        if (!found && miss_total != '1) begin
          miss_total <= miss_total + TOTAL_W'(1);
        end
        if (res_evicted && eviction_total != '1) begin
          eviction_total <= eviction_total + TOTAL_W'(1);
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_hit_count <= res_hit_count;
      out_missed    <= !found;
      out_evicted   <= res_evicted;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, eviction_total, miss_total, hit_total,
                     out_evicted, out_missed, out_hit_count};

`ifndef NO_ASSERTIONS
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == salc_pkg::ST_LOOKUP)
    else $error("accepted word did not move to lookup");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == salc_pkg::ST_IDLE |-> !ram_wr_en)
    else $error("row RAM written while idle");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hit_total >= $past(hit_total))
    else $error("hit total decreased");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_evicted |-> out_missed && out_hit_count != 2'd2)
    else $error("eviction reported without a miss");
`endif

endmodule

// ===== rtl/salc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
